FILE: hdl/tte_pkg.sv
`timescale 1ns / 1ps
// Package for the tap tempo estimator: command and register codes, tone and
// tempo constants, and the packed input and result types. No dependencies.
package tte_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned BPM_W  = 9;
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 16;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_TAP    = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_ENTER  = 3'd4;

  localparam logic [CFG_AW-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SOUND   = 1'b1;

  localparam int unsigned  MS_PER_MIN    = 60000;
  localparam logic [8:0]   BPM_MIN       = 9'd30;
  localparam logic [8:0]   BPM_MAX       = 9'd300;
  localparam logic [31:0]  FLASH_HOLD_MS = 32'd50;
  localparam logic [15:0]  TIMEOUT_RST   = 16'd2500;

  localparam logic [10:0] TONE_CLICK_HZ = 11'd1500;
  localparam logic [10:0] TONE_HI_HZ    = 11'd1200;
  localparam logic [10:0] TONE_TAP_HZ   = 11'd1000;
  localparam logic [10:0] TONE_LO_HZ    = 11'd800;
  localparam logic [10:0] TONE_CLR_HZ   = 11'd400;
  localparam logic [6:0]  TONE_SHORT_MS = 7'd50;
  localparam logic [6:0]  TONE_CLICK_MS = 7'd30;
  localparam logic [6:0]  TONE_LONG_MS  = 7'd100;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [BPM_W-1:0]  bpm;
    logic              locked;
    logic [3:0]        tap_count;
    logic [TIME_W-1:0] beat_interval_ms;
    logic              flash;
    logic              beat;
    logic              sound_on;
    logic [10:0]       tone_hz;
    logic [6:0]        tone_ms;
  } out_t;

endpackage

FILE: hdl/tap_tempo_estimator_top.sv
`timescale 1ns / 1ps
// Top level of the tap tempo estimator: command decode, tap history, window sum
// and one shared restoring divider under a small sequencer. Uses tte_pkg.
//
// One command is taken at a time and its result is held in an output register,
// so the next command is taken while that result waits to be transferred. Tick,
// toggle, clear and enter, and a tap that leaves fewer than two taps in the
// history, pass from the execute state straight to the result state. A tap that
// leaves two or more taps walks the history for the sum of the n averaged
// intervals, divides it by n for the average interval and then divides 60000 * n
// by the sum for the tempo. When the window sum is zero the tempo division is
// skipped. The shared divider makes one quotient bit a cycle, over SUM_W bits (32
// plus the bits of WINDOW_INTERVALS) for the average and PROD_W bits (the bits of
// 60000 * WINDOW_INTERVALS) for the tempo. A result waits in the result state
// until an earlier result still held in the output register has been transferred.
module tap_tempo_estimator_top
  import tte_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH    = 8,
  parameter int unsigned WINDOW_INTERVALS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int unsigned HW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned IW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned NW     = $clog2(WINDOW_INTERVALS + 1);
  localparam int unsigned SUM_W  = TIME_W + NW;
  localparam int unsigned PROD_W = $clog2(MS_PER_MIN * WINDOW_INTERVALS + 1);
  localparam int unsigned CW     = $clog2(SUM_W + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_EXEC   = 8'b00000010,
    ST_HIST   = 8'b00000100,
    ST_AVG_LD = 8'b00001000,
    ST_AVG    = 8'b00010000,
    ST_BPM_LD = 8'b00100000,
    ST_BPM    = 8'b01000000,
    ST_RESULT = 8'b10000000
  } state_e;

  state_e            state_q, state_d;
  logic [HW-1:0]     held_q, held_d;
  logic [BPM_W-1:0]  tempo_q, tempo_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              locked_q, locked_d;
  logic [TIME_W-1:0] avg_q, avg_d;
  logic              pos_q, pos_d;
  logic [TIME_W-1:0] next_q, next_d;
  logic              flash_q, flash_d;
  logic              click_q, click_d;
  logic [15:0]       timeout_q, timeout_d;
  logic              sound_q, sound_d;
  logic              out_valid_q, out_valid_d;
  logic              beat_q, beat_d;

  logic [TIME_W-1:0] times_q [HISTORY_DEPTH];
  logic [TIME_W-1:0] times_d [HISTORY_DEPTH];
  logic [2:0]        cmd_q, cmd_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              fst_q, fst_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [NW-1:0]     n_q, n_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [SUM_W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  out_t              out_q, out_d;

  logic              in_acc;
  logic [TIME_W-1:0] gap;
  logic              restart;
  logic [HW-1:0]     held_base;
  logic [HW-1:0]     held_new;
  logic [HW-1:0]     first_new;
  logic              fire;
  logic [TIME_W-1:0] rd_data;
  logic [TIME_W-1:0] diff;
  logic [SUM_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  rem_nx;
  logic [SUM_W-1:0]  quo_nx;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] qb;
  logic [BPM_W-1:0]  bpm_clamp;
  logic [10:0]       tone_hz;
  logic [6:0]        tone_ms;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign gap       = now_q - last_q;
  assign restart   = (held_q != '0) && (gap > {16'b0, timeout_q});
  assign held_base = restart ? '0 : held_q;
  assign held_new  = (held_base < HW'(HISTORY_DEPTH)) ? held_base + 1'b1 : held_base;
  assign first_new = (int'(held_new) > int'(WINDOW_INTERVALS)) ?
                     HW'(int'(held_new) - int'(WINDOW_INTERVALS)) : HW'(1);
  assign fire      = locked_q && pos_q && (now_q >= next_q);

  assign rd_data = times_q[idx_q];
  assign diff    = rd_data - prev_q;

  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? SUM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[SUM_W-1:0];
  assign quo_nx = {quo_q[SUM_W-2:0], ge};

  assign prod = PROD_W'(MS_PER_MIN) * PROD_W'(n_q);
  assign qb   = quo_nx[PROD_W-1:0];

  always_comb begin
    if (qb < PROD_W'(BPM_MIN)) begin
      bpm_clamp = BPM_MIN;
    end else if (qb > PROD_W'(BPM_MAX)) begin
      bpm_clamp = BPM_MAX;
    end else begin
      bpm_clamp = BPM_W'(qb);
    end
  end

  always_comb begin
    tone_hz = '0;
    tone_ms = '0;
    case (cmd_q)
      CMD_TICK: begin
        if (beat_q && click_q) begin
          tone_hz = TONE_CLICK_HZ;
          tone_ms = TONE_CLICK_MS;
        end
      end
      CMD_TAP: begin
        tone_hz = locked_q ? TONE_HI_HZ : TONE_TAP_HZ;
        tone_ms = TONE_SHORT_MS;
      end
      CMD_TOGGLE: begin
        tone_hz = click_q ? TONE_HI_HZ : TONE_LO_HZ;
        tone_ms = TONE_SHORT_MS;
      end
      CMD_CLEAR: begin
        tone_hz = TONE_CLR_HZ;
        tone_ms = TONE_LONG_MS;
      end
      default: begin
        tone_hz = '0;
        tone_ms = '0;
      end
    endcase
    if (!sound_q) begin
      tone_hz = '0;
      tone_ms = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    tempo_d     = tempo_q;
    last_d      = last_q;
    locked_d    = locked_q;
    avg_d       = avg_q;
    pos_d       = pos_q;
    next_d      = next_q;
    flash_d     = flash_q;
    click_d     = click_q;
    timeout_d   = timeout_q;
    sound_d     = sound_q;
    beat_d      = beat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    times_d     = times_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    idx_d       = idx_q;
    fst_d       = fst_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    n_d         = n_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TIMEOUT: timeout_d = cfg_wdata_i[15:0];
        REG_SOUND:   sound_d   = cfg_wdata_i[0];
        default:     timeout_d = timeout_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = in_data_i.cmd;
          now_d   = in_data_i.now_ms;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        beat_d  = 1'b0;
        state_d = ST_RESULT;
        case (cmd_q)
          CMD_TICK: begin
            if (fire) begin
              beat_d  = 1'b1;
              next_d  = now_q + avg_q;
              flash_d = 1'b0;
            end else if (flash_q && (gap > FLASH_HOLD_MS)) begin
              flash_d = 1'b0;
            end
          end
          CMD_TAP: begin
            if (restart) begin
              tempo_d  = '0;
              locked_d = 1'b0;
              avg_d    = '0;
              pos_d    = 1'b0;
            end
            last_d  = now_q;
            flash_d = 1'b1;
            held_d  = held_new;
            if (held_base < HW'(HISTORY_DEPTH)) begin
              times_d[held_base[IW-1:0]] = now_q;
            end else begin
              for (int j = 0; j < int'(HISTORY_DEPTH) - 1; j++) begin
                times_d[j] = times_q[j+1];
              end
              times_d[HISTORY_DEPTH-1] = now_q;
            end
            if (held_new >= HW'(2)) begin
              idx_d   = IW'(first_new - 1'b1);
              n_d     = NW'(held_new - first_new);
              fst_d   = 1'b1;
              sum_d   = '0;
              state_d = ST_HIST;
            end
          end
          CMD_TOGGLE: click_d = ~click_q;
          CMD_CLEAR, CMD_ENTER: begin
            held_d   = '0;
            tempo_d  = '0;
            last_d   = '0;
            locked_d = 1'b0;
            avg_d    = '0;
            pos_d    = 1'b0;
            next_d   = '0;
            flash_d  = 1'b0;
            if (cmd_q == CMD_ENTER) begin
              click_d = 1'b0;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_HIST: begin
        prev_d = rd_data;
        fst_d  = 1'b0;
        if (!fst_q) begin
          sum_d = sum_q + SUM_W'(diff);
        end
        if (idx_q == IW'(held_q - 1'b1)) begin
          state_d = ST_AVG_LD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_AVG_LD: begin
        rem_d   = '0;
        quo_d   = sum_q;
        dvs_d   = SUM_W'(n_q);
        cnt_d   = CW'(SUM_W);
        state_d = ST_AVG;
      end
      ST_AVG: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          avg_d    = quo_nx[TIME_W-1:0];
          pos_d    = (sum_q != '0);
          locked_d = (held_q >= HW'(3)) && (HISTORY_DEPTH >= 3);
          next_d   = now_q + quo_nx[TIME_W-1:0];
          if (sum_q == '0) begin
            tempo_d = BPM_MAX;
            state_d = ST_RESULT;
          end else begin
            state_d = ST_BPM_LD;
          end
        end
      end
      ST_BPM_LD: begin
        rem_d   = '0;
        quo_d   = SUM_W'(prod) << (SUM_W - PROD_W);
        dvs_d   = sum_q;
        cnt_d   = CW'(PROD_W);
        state_d = ST_BPM;
      end
      ST_BPM: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          tempo_d = bpm_clamp;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.bpm              = tempo_q;
          out_d.locked           = locked_q;
          out_d.tap_count        = 4'(held_q);
          out_d.beat_interval_ms = avg_q;
          out_d.flash            = flash_q;
          out_d.beat             = beat_q;
          out_d.sound_on         = click_q;
          out_d.tone_hz          = tone_hz;
          out_d.tone_ms          = tone_ms;
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      tempo_q     <= '0;
      last_q      <= '0;
      locked_q    <= 1'b0;
      avg_q       <= '0;
      pos_q       <= 1'b0;
      next_q      <= '0;
      flash_q     <= 1'b0;
      click_q     <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
      sound_q     <= 1'b1;
      out_valid_q <= 1'b0;
      beat_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      tempo_q     <= tempo_d;
      last_q      <= last_d;
      locked_q    <= locked_d;
      avg_q       <= avg_d;
      pos_q       <= pos_d;
      next_q      <= next_d;
      flash_q     <= flash_d;
      click_q     <= click_d;
      timeout_q   <= timeout_d;
      sound_q     <= sound_d;
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    times_q <= times_d;
    cmd_q   <= cmd_d;
    now_q   <= now_d;
    idx_q   <= idx_d;
    fst_q   <= fst_d;
    prev_q  <= prev_d;
    sum_q   <= sum_d;
    n_q     <= n_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
    out_q   <= out_d;
  end

  // A transfer in always starts command execution on the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted command did not start execution");

  // The tempo is locked only with at least three taps in the history.
  a_locked_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |-> (held_q >= HW'(3)))
    else $error("locked with fewer than three taps");

  // A stored tempo is either zero or inside the clamp range.
  a_tempo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tempo_q == '0) || ((tempo_q >= BPM_MIN) && (tempo_q <= BPM_MAX)))
    else $error("tempo outside clamp range");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_AVG) || (state_q == ST_BPM)) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  // The history never holds more taps than its depth.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(HISTORY_DEPTH))
    else $error("tap count beyond history depth");

endmodule
